// ===== hw/rtl/wst_pkg.sv =====
package wst_pkg;

  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned ADDR_W       = 5;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned SQRT_STEPS   = 13;
  localparam int unsigned ROOT_BITS    = 12;

  localparam logic [33:0] RAD100_SQ    = 34'd10000;
  localparam logic [33:0] RAMP_SQ      = 34'd25000000;
  localparam int unsigned RAMP_DIST    = 5000;
  localparam logic [28:0] RAMP_RECIP   = 29'd439804652;
  localparam logic [16:0] TURN_TOL     = 17'd546;
  localparam logic [16:0] TURN_SPAN    = 17'd10923;
  localparam logic [16:0] QUARTER_TURN = 17'd16384;
  localparam int unsigned D_FLOOR      = 22938;
  localparam logic [14:0] MOVE_RAD     = 15'd100;

  localparam logic [14:0] MAX_SPEED_RST  = 15'd9830;
  localparam logic [14:0] MIN_SPEED_RST  = 15'd8192;
  localparam logic [14:0] FINAL_RAD_RST  = 15'd100;
  localparam logic [14:0] VIA_RAD_RST    = 15'd1000;
  localparam logic [14:0] FINAL_HTOL_RST = 15'd31;
  localparam logic [14:0] VIA_HTOL_RST   = 15'd15646;

  typedef struct packed {
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic signed [15:0] robot_heading;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_heading;
    logic [2:0]         mode;
  } in_beat_t;

  typedef struct packed {
    logic               reached;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } out_beat_t;

  typedef struct packed {
    logic [14:0] max_speed;
    logic [14:0] min_speed;
    logic [14:0] final_radius;
    logic [14:0] via_radius;
    logic [14:0] final_heading_tol;
    logic [14:0] via_heading_tol;
  } cfg_t;

  typedef enum logic [2:0] {
    KIND_FINAL    = 3'd0,
    KIND_PREFINAL = 3'd1,
    KIND_VIA      = 3'd2,
    KIND_MOVE     = 3'd3,
    KIND_TURN     = 3'd4,
    KIND_OTHER    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    REG_MAX_SPEED  = 3'd0,
    REG_MIN_SPEED  = 3'd1,
    REG_FINAL_RAD  = 3'd2,
    REG_VIA_RAD    = 3'd3,
    REG_FINAL_HTOL = 3'd4,
    REG_VIA_HTOL   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [15:0]        robot_heading;
    logic [15:0]        target_heading;
    logic [15:0]        dh;
    kind_e              kind;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ1,
    ST_SQ2,
    ST_CORD,
    ST_SCALE,
    ST_DIV,
    ST_MOVE1,
    ST_MOVE2,
    ST_ROOT,
    ST_TURN1,
    ST_TURN2,
    ST_DONE
  } back_state_e;

  function automatic logic [31:0] atan_entry(input logic [3:0] i);
    logic [31:0] v;
    case (i)
      4'd0:    v = 32'd536870912;
      4'd1:    v = 32'd316933406;
      4'd2:    v = 32'd167458907;
      4'd3:    v = 32'd85004756;
      4'd4:    v = 32'd42667331;
      4'd5:    v = 32'd21354465;
      4'd6:    v = 32'd10680862;
      4'd7:    v = 32'd5340245;
      4'd8:    v = 32'd2670163;
      4'd9:    v = 32'd1335087;
      4'd10:   v = 32'd667544;
      4'd11:   v = 32'd333772;
      4'd12:   v = 32'd166886;
      4'd13:   v = 32'd83443;
      4'd14:   v = 32'd41722;
      default: v = 32'd20861;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] abs_ang(input logic [15:0] a);
    return a[15] ? (17'h10000 - {1'b0, a}) : {1'b0, a};
  endfunction

endpackage

// ===== hw/rtl/wst_queue.sv =====
module wst_queue import wst_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/wst_front.sv =====
module wst_front import wst_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_beat_t in_data_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output job_t     job_data_o
);

  kind_e kind;

  always_comb begin
    case (in_data_i.mode)
      KIND_FINAL:    kind = KIND_FINAL;
      KIND_PREFINAL: kind = KIND_PREFINAL;
      KIND_VIA:      kind = KIND_VIA;
      KIND_MOVE:     kind = KIND_MOVE;
      KIND_TURN:     kind = KIND_TURN;
      default:       kind = KIND_OTHER;
    endcase
  end

  always_comb begin
    job_data_o.dx = {in_data_i.target_x[15], in_data_i.target_x}
                  - {in_data_i.robot_x[15], in_data_i.robot_x};
    job_data_o.dy = {in_data_i.target_y[15], in_data_i.target_y}
                  - {in_data_i.robot_y[15], in_data_i.robot_y};
    job_data_o.robot_heading  = in_data_i.robot_heading;
    job_data_o.target_heading = in_data_i.target_heading;
    job_data_o.dh   = in_data_i.robot_heading - in_data_i.target_heading;
    job_data_o.kind = kind;
  end

  assign job_valid_o = in_valid_i;
  assign in_ready_o  = job_ready_i;

endmodule

// ===== hw/rtl/wst_back.sv =====
module wst_back import wst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  job_t      job_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam logic [18:0] HALF_CLIP = 19'(32768 - D_FLOOR);

  back_state_e state_q, state_d;
  logic        out_load;

  job_t               job_q;
  logic [3:0]         cnt_q;
  logic [1:0]         sub_q;
  logic [32:0]        sqx_q;
  logic [33:0]        d2_q;
  logic [29:0]        rad2_q;
  logic signed [31:0] cx_q, cy_q;
  logic [31:0]        cz_q;
  logic [15:0]        phi_q;
  logic [25:0]        sq_v_q;
  logic [15:0]        sq_rem_q;
  logic [12:0]        sq_root_q;
  logic [27:0]        div_rem_q;
  logic [14:0]        quo_q;
  logic [14:0]        pw_q;
  logic [15:0]        dd_q;
  logic               sgn_q, big_q;
  logic [16:0]        q_q;
  logic [11:0]        lo_q, c_q;
  logic [23:0]        c2_q;
  logic [47:0]        c4_q;
  logic [14:0]        y_q;
  logic signed [15:0] left_q, right_q;
  logic               out_valid_q;
  out_beat_t          out_q;

  logic signed [33:0] dx_sq, dy_sq;
  logic [33:0]        d2_sum;
  logic [14:0]        rad_sel;
  logic signed [31:0] x0, y0, cx_sh, cy_sh;
  logic [15:0]        sq_acc, sq_trial;
  logic [56:0]        div_prod;
  logic [15:0]        da_mv;
  logic [16:0]        a_mv, a_t, herr;
  logic [19:0]        a7;
  logic [18:0]        half;
  logic [14:0]        pw_mv, pw_t, pw_sel;
  logic [30:0]        dp_prod;
  logic [11:0]        c_w;
  logic [59:0]        c5;
  logic [28:0]        yq;
  logic [29:0]        pm;
  logic [15:0]        pt;
  logic               okxy, oka;

  assign dx_sq  = job_q.dx * job_q.dx;
  assign dy_sq  = job_q.dy * job_q.dy;
  assign d2_sum = {1'b0, sqx_q} + {1'b0, dy_sq[32:0]};
  assign x0 = {{3{job_q.dx[16]}}, job_q.dx, 12'b0};
  assign y0 = {{3{job_q.dy[16]}}, job_q.dy, 12'b0};
  assign cx_sh = cx_q >>> cnt_q;
  assign cy_sh = cy_q >>> cnt_q;
  assign sq_acc   = {sq_rem_q[13:0], sq_v_q[25:24]};
  assign sq_trial = {1'b0, sq_root_q, 2'b01};
  assign div_prod = div_rem_q * RAMP_RECIP;
  assign da_mv = job_q.robot_heading - phi_q;
  assign a_mv  = abs_ang(da_mv);
  assign a_t   = abs_ang(job_q.dh);
  assign herr  = a_t;
  assign a7    = {a_mv, 3'b0} - {3'b0, a_mv};
  assign half  = a7[19:1];
  assign pw_mv = (d2_q > RAMP_SQ) ? cfg_i.max_speed : quo_q;
  assign dp_prod = dd_q * pw_q;
  assign c_w   = lo_q | (12'd1 << cnt_q);
  assign c5    = c4_q * c_q;
  assign yq    = q_q * lo_q;
  assign pm    = cfg_i.max_speed * y_q;
  assign pw_t  = big_q ? cfg_i.max_speed : pm[29:15];
  assign pt    = phi_q - job_q.target_heading;

  always_comb begin
    case (job_q.kind)
      KIND_FINAL, KIND_PREFINAL: rad_sel = cfg_i.final_radius;
      KIND_VIA:                  rad_sel = cfg_i.via_radius;
      default:                   rad_sel = MOVE_RAD;
    endcase
  end

  always_comb begin
    pw_sel = (state_q == ST_MOVE1) ? pw_mv : pw_t;
    if (pw_sel < cfg_i.min_speed) begin
      pw_sel = cfg_i.min_speed;
    end
  end

  always_comb begin
    okxy = 1'b1;
    oka  = 1'b1;
    case (job_q.kind)
      KIND_FINAL: begin
        okxy = d2_q < {4'b0, rad2_q};
        oka  = herr < {2'b0, cfg_i.final_heading_tol};
      end
      KIND_PREFINAL: okxy = d2_q < {4'b0, rad2_q};
      KIND_VIA: begin
        okxy = d2_q < {4'b0, rad2_q};
        oka  = herr < {2'b0, cfg_i.via_heading_tol};
      end
      KIND_MOVE: okxy = (d2_q < RAD100_SQ) || (abs_ang(pt) >= QUARTER_TURN);
      KIND_TURN: oka  = herr < TURN_TOL;
      default: begin
        okxy = 1'b1;
        oka  = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (job_valid_i) state_d = ST_SQ1;
      ST_SQ1:   state_d = ST_SQ2;
      ST_SQ2: begin
        if (job_q.kind == KIND_MOVE) begin
          state_d = ST_CORD;
        end else if (job_q.kind == KIND_TURN) begin
          state_d = ST_ROOT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CORD:  if (cnt_q == 4'(CORDIC_STEPS - 1)) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DIV;
      ST_DIV:   state_d = ST_MOVE1;
      ST_MOVE1: state_d = ST_MOVE2;
      ST_MOVE2: state_d = ST_DONE;
      ST_ROOT:  if (sub_q == 2'd2 && cnt_q == '0) state_d = ST_TURN1;
      ST_TURN1: state_d = ST_TURN2;
      ST_TURN2: state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = (state_q == ST_IDLE);
    out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.reached     <= okxy && oka;
      out_q.left_speed  <= left_q;
      out_q.right_speed <= right_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) job_q <= job_data_i;
      end
      ST_SQ1: begin
        sqx_q   <= dx_sq[32:0];
        rad2_q  <= rad_sel * rad_sel;
        left_q  <= '0;
        right_q <= '0;
        if (job_q.dx[16]) begin
          cx_q <= -x0;
          cy_q <= -y0;
          cz_q <= 32'h8000_0000;
        end else begin
          cx_q <= x0;
          cy_q <= y0;
          cz_q <= '0;
        end
      end
      ST_SQ2: begin
        d2_q      <= d2_sum;
        sq_v_q    <= d2_sum[25:0];
        sq_rem_q  <= '0;
        sq_root_q <= '0;
        q_q       <= 17'(a_t * 3'd6);
        big_q     <= (a_t >= TURN_SPAN);
        sgn_q     <= job_q.dh[15];
        lo_q      <= '0;
        sub_q     <= '0;
        cnt_q     <= (job_q.kind == KIND_TURN) ? 4'(ROOT_BITS - 1) : '0;
      end
      ST_CORD: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + cy_sh;
          cy_q <= cy_q - cx_sh;
          cz_q <= cz_q + atan_entry(cnt_q);
        end else begin
          cx_q <= cx_q - cy_sh;
          cy_q <= cy_q + cx_sh;
          cz_q <= cz_q - atan_entry(cnt_q);
        end
        if (cnt_q < 4'(SQRT_STEPS)) begin
          sq_v_q <= {sq_v_q[23:0], 2'b00};
          if (sq_acc >= sq_trial) begin
            sq_rem_q  <= sq_acc - sq_trial;
            sq_root_q <= {sq_root_q[11:0], 1'b1};
          end else begin
            sq_rem_q  <= sq_acc;
            sq_root_q <= {sq_root_q[11:0], 1'b0};
          end
        end
        cnt_q <= cnt_q + 4'd1;
      end
      ST_SCALE: begin
        div_rem_q <= cfg_i.max_speed * sq_root_q;
        cnt_q     <= '0;
        if (job_q.dx == '0 && job_q.dy == '0) begin
          phi_q <= '0;
        end else begin
          phi_q <= 16'((cz_q + 32'h8000) >> 16);
        end
      end
      ST_DIV: begin
        // divide by the ramp distance: multiply by 2^41 / 5000, rounded up
        quo_q <= div_prod[55:41];
      end
      ST_MOVE1: begin
        pw_q  <= pw_sel;
        dd_q  <= (half > HALF_CLIP) ? 16'(D_FLOOR) : 16'(19'd32768 - half);
        sgn_q <= da_mv[15];
      end
      ST_MOVE2: begin
        if (!sgn_q) begin
          left_q  <= $signed(dp_prod[30:15]);
          right_q <= $signed({1'b0, pw_q});
        end else begin
          left_q  <= $signed({1'b0, pw_q});
          right_q <= $signed(dp_prod[30:15]);
        end
      end
      ST_ROOT: begin
        case (sub_q)
          2'd0: begin
            c_q   <= c_w;
            c2_q  <= c_w * c_w;
            sub_q <= 2'd1;
          end
          2'd1: begin
            c4_q  <= c2_q * c2_q;
            sub_q <= 2'd2;
          end
          default: begin
            if ({1'b0, c5} <= {q_q, 44'b0}) lo_q <= c_q;
            cnt_q <= cnt_q - 4'd1;
            sub_q <= 2'd0;
          end
        endcase
      end
      ST_TURN1: y_q <= yq[27:13];
      ST_TURN2: begin
        if (!sgn_q) begin
          left_q  <= -$signed({1'b0, pw_sel});
          right_q <= $signed({1'b0, pw_sel});
        end else begin
          left_q  <= $signed({1'b0, pw_sel});
          right_q <= -$signed({1'b0, pw_sel});
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/waypoint_step_tracker.sv =====
// Waypoint step tracker: each input beat (robot pose, step target, step kind) yields one
// result beat (reached flag, left and right wheel speed). The front computes offsets and
// a queue holds beats, so input is taken while the back works; the back handles one
// beat at a time: a move step runs a 16-step bearing CORDIC with the square root
// alongside, then one reciprocal multiplication for the division by the ramp distance;
// a turn step finds a 12-bit fifth root, squaring twice, multiplying and comparing per
// bit. Results wait in an output register.
module waypoint_step_tracker import wst_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_beat_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_beat_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t     cfg_q;
  logic     fj_valid, fj_ready, bj_valid, bj_ready;
  job_t     fj_data, bj_data;
  reg_idx_e widx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_speed         <= MAX_SPEED_RST;
      cfg_q.min_speed         <= MIN_SPEED_RST;
      cfg_q.final_radius      <= FINAL_RAD_RST;
      cfg_q.via_radius        <= VIA_RAD_RST;
      cfg_q.final_heading_tol <= FINAL_HTOL_RST;
      cfg_q.via_heading_tol   <= VIA_HTOL_RST;
    end else if (wr_en) begin
      case (widx)
        REG_MAX_SPEED:  cfg_q.max_speed         <= pwdata[14:0];
        REG_MIN_SPEED:  cfg_q.min_speed         <= pwdata[14:0];
        REG_FINAL_RAD:  cfg_q.final_radius      <= pwdata[14:0];
        REG_VIA_RAD:    cfg_q.via_radius        <= pwdata[14:0];
        REG_FINAL_HTOL: cfg_q.final_heading_tol <= pwdata[14:0];
        REG_VIA_HTOL:   cfg_q.via_heading_tol   <= pwdata[14:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_MAX_SPEED:  prdata = {17'b0, cfg_q.max_speed};
      REG_MIN_SPEED:  prdata = {17'b0, cfg_q.min_speed};
      REG_FINAL_RAD:  prdata = {17'b0, cfg_q.final_radius};
      REG_VIA_RAD:    prdata = {17'b0, cfg_q.via_radius};
      REG_FINAL_HTOL: prdata = {17'b0, cfg_q.final_heading_tol};
      REG_VIA_HTOL:   prdata = {17'b0, cfg_q.via_heading_tol};
      default:        prdata = '0;
    endcase
  end

  wst_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_data_o  (fj_data)
  );

  wst_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_data_i  (fj_data),
    .pop_valid_o  (bj_valid),
    .pop_ready_i  (bj_ready),
    .pop_data_o   (bj_data)
  );

  wst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_data_i  (bj_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import wst_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 20000;
  localparam int unsigned DRAIN_WAIT  = 80;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [2:0]  REG_SPARE   = 3'd6;
  localparam logic [2:0]  KIND_SPARE6 = 3'd6;
  localparam logic [2:0]  KIND_SPARE7 = 3'd7;

  class wst_board;
    cfg_t      cfg;
    out_beat_t pending[$];
    int        errors;

    function new();
      cfg.max_speed = MAX_SPEED_RST;
      cfg.min_speed = MIN_SPEED_RST;
      cfg.final_radius = FINAL_RAD_RST;
      cfg.via_radius = VIA_RAD_RST;
      cfg.final_heading_tol = FINAL_HTOL_RST;
      cfg.via_heading_tol = VIA_HTOL_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_MAX_SPEED:  cfg.max_speed = v[14:0];
        REG_MIN_SPEED:  cfg.min_speed = v[14:0];
        REG_FINAL_RAD:  cfg.final_radius = v[14:0];
        REG_VIA_RAD:    cfg.via_radius = v[14:0];
        REG_FINAL_HTOL: cfg.final_heading_tol = v[14:0];
        REG_VIA_HTOL:   cfg.via_heading_tol = v[14:0];
        default: ;
      endcase
    endfunction

    function int wrap_abs(int v);
      logic signed [15:0] w;
      w = v[15:0];
      return (w < 0) ? -int'(w) : int'(w);
    endfunction

    function int heading_of(int dx, int dy);
      longint x, y, xs, ys;
      logic [31:0] z, zr;
      x = longint'(dx) * 4096;
      y = longint'(dy) * 4096;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += atan_entry(i[3:0]);
        end else begin
          x -= ys; y += xs; z -= atan_entry(i[3:0]);
        end
      end
      zr = (z + 32'h8000) >> 16;
      return int'($signed(zr[15:0]));
    endfunction

    function longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned fifth_root(longint unsigned t);
      longint unsigned lo, c;
      lo = 0;
      for (int b = 11; b >= 0; b--) begin
        c = lo | (64'd1 << b);
        if (c * c * c * c * c <= t) lo = c;
      end
      return lo;
    endfunction

    function out_beat_t predict(in_beat_t b);
      out_beat_t r;
      int dx, dy, herr, phi, da, a, d;
      longint unsigned d2, pw, dp, q, s, yq, fr2, vr2;
      bit okxy, oka;
      dx = int'(b.target_x) - int'(b.robot_x);
      dy = int'(b.target_y) - int'(b.robot_y);
      d2 = longint'(dx) * dx + longint'(dy) * dy;
      herr = wrap_abs(int'(b.robot_heading) - int'(b.target_heading));
      phi = heading_of(dx, dy);
      fr2 = longint'(cfg.final_radius) * cfg.final_radius;
      vr2 = longint'(cfg.via_radius) * cfg.via_radius;
      okxy = 1;
      oka = 1;
      r = '0;
      case (b.mode)
        KIND_FINAL: begin
          okxy = d2 < fr2;
          oka = herr < int'(cfg.final_heading_tol);
        end
        KIND_PREFINAL: okxy = d2 < fr2;
        KIND_VIA: begin
          okxy = d2 < vr2;
          oka = herr < int'(cfg.via_heading_tol);
        end
        KIND_MOVE: okxy = d2 < RAD100_SQ || wrap_abs(phi - int'(b.target_heading)) >= 16384;
        KIND_TURN: oka = herr < int'(TURN_TOL);
        default: ;
      endcase
      if (b.mode == KIND_MOVE) begin
        da = int'($signed(16'(int'(b.robot_heading) - phi)));
        a = (da < 0) ? -da : da;
        d = 32768 - (a * 7) / 2;
        if (d2 > RAMP_SQ) pw = cfg.max_speed;
        else pw = (longint'(cfg.max_speed) * sqrt_floor(d2)) / RAMP_DIST;
        if (pw < cfg.min_speed) pw = cfg.min_speed;
        if (d < int'(D_FLOOR)) d = int'(D_FLOOR);
        dp = (longint'(d) * pw) >> 15;
        if (da >= 0) begin
          r.left_speed = dp[15:0]; r.right_speed = pw[15:0];
        end else begin
          r.left_speed = pw[15:0]; r.right_speed = dp[15:0];
        end
      end else if (b.mode == KIND_TURN) begin
        da = int'($signed(16'(int'(b.robot_heading) - int'(b.target_heading))));
        a = (da < 0) ? -da : da;
        if (a >= int'(TURN_SPAN)) begin
          pw = cfg.max_speed;
        end else begin
          q = longint'(a) * 6;
          s = fifth_root(q << 44);
          yq = (q * s) >> 13;
          pw = (longint'(cfg.max_speed) * yq) >> 15;
        end
        if (pw < cfg.min_speed) pw = cfg.min_speed;
        if (da >= 0) begin
          r.left_speed = -pw[15:0]; r.right_speed = pw[15:0];
        end else begin
          r.left_speed = pw[15:0]; r.right_speed = -pw[15:0];
        end
      end
      r.reached = okxy && oka;
      return r;
    endfunction

    function void note(in_beat_t b);
      pending = {pending, predict(b)};
    endfunction

    task report(string what, int got, int want);
      $display("step result: %s got %0d want %0d", what, got, want);
      errors++;
    endtask

    task check(out_beat_t r);
      out_beat_t e;
      if (pending.size() == 0) begin
        report("unexpected beat, reached", r.reached, 0);
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (r.reached !== e.reached) report("reached", r.reached, e.reached);
      if (r.left_speed !== e.left_speed) report("left_speed", r.left_speed, e.left_speed);
      if (r.right_speed !== e.right_speed) report("right_speed", r.right_speed, e.right_speed);
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  in_beat_t          in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_beat_t         out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  wst_board board = new();
  int unsigned n_sent = 0;
  int unsigned idle_cnt = 0;
  int unsigned hold_cnt = 0;
  bit          hold_done = 0;

  waypoint_step_tracker u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && n_sent >= 300) begin
      hold_done <= 1;
      hold_cnt <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (n_sent < 150 || n_sent > 650) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check(out_data_o);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("waypoint_step_tracker: mismatch");
        $finish;
      end
    end
  end

  task send(in_beat_t b, int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note(b);
    n_sent++;
  endtask

  task write_reg(logic [2:0] idx, logic [14:0] v);
    logic [31:0] word;
    word = {17'($urandom_range(0, 131071)), v};
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.set_reg(idx, word);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function in_beat_t beat(int rx, int ry, int rh, int tx, int ty, int th, logic [2:0] m);
    in_beat_t b;
    b.robot_x = rx[15:0]; b.robot_y = ry[15:0]; b.robot_heading = rh[15:0];
    b.target_x = tx[15:0]; b.target_y = ty[15:0]; b.target_heading = th[15:0];
    b.mode = m;
    return b;
  endfunction

  function int near(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function in_beat_t random_beat();
    in_beat_t b;
    int span, hspan;
    b = in_beat_t'(99'({$urandom(), $urandom(), $urandom()}));
    case ($urandom_range(0, 3))
      0: span = 160;
      1: span = 1500;
      2: span = 9000;
      default: span = 0;
    endcase
    if (span != 0) begin
      b.target_x = 16'(b.robot_x + near(span));
      b.target_y = 16'(b.robot_y + near(span));
    end
    case ($urandom_range(0, 3))
      0: hspan = 40;
      1: hspan = 700;
      2: hspan = 16000;
      default: hspan = 0;
    endcase
    if (hspan != 0) b.robot_heading = 16'(b.target_heading + near(hspan));
    b.mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
    return b;
  endfunction

  task random_run(int unsigned n);
    for (int unsigned k = 0; k < n; k++) send(random_beat(), pick_gap());
  endtask

  task write_all(logic [14:0] mx, logic [14:0] mn, logic [14:0] fr,
                 logic [14:0] vr, logic [14:0] fh, logic [14:0] vh);
    write_reg(REG_MAX_SPEED, mx);
    write_reg(REG_MIN_SPEED, mn);
    write_reg(REG_FINAL_RAD, fr);
    write_reg(REG_VIA_RAD, vr);
    write_reg(REG_FINAL_HTOL, fh);
    write_reg(REG_VIA_HTOL, vh);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(beat(0, 0, 0, 0, 0, 0, KIND_FINAL), 0);
    send(beat(0, 0, 0, 0, 0, 0, KIND_PREFINAL), 0);
    send(beat(0, 0, 0, 0, 0, 0, KIND_VIA), 0);
    send(beat(0, 0, 0, 0, 0, 0, KIND_MOVE), 0);
    send(beat(0, 0, 0, 0, 0, 0, KIND_TURN), 0);
    send(beat(0, 0, 0, 0, 0, 0, KIND_OTHER), 0);
    send(beat(5, 5, 100, 9, 9, 0, KIND_SPARE6), 1);
    send(beat(5, 5, 100, 9, 9, 0, KIND_SPARE7), 0);
    send(beat(-32768, -32768, -32768, 32767, 32767, 32767, KIND_MOVE), 0);
    send(beat(32767, 32767, 32767, -32768, -32768, -32768, KIND_FINAL), 0);
    send(beat(0, 0, 0, 99, 0, 30, KIND_FINAL), 0);
    send(beat(0, 0, 0, 100, 0, 31, KIND_FINAL), 2);
    send(beat(0, 0, 0, 999, 0, 15645, KIND_VIA), 0);
    send(beat(0, 0, 16384, 5000, 0, 0, KIND_MOVE), 0);
    send(beat(0, 0, -16384, 5001, 0, 0, KIND_MOVE), 0);
    send(beat(2000, 0, 0, 0, 0, 0, KIND_MOVE), 0);
    send(beat(0, 0, 0, 70, 70, 8192, KIND_MOVE), 0);
    send(beat(0, 0, 10923, 0, 0, 0, KIND_TURN), 0);
    send(beat(0, 0, 10922, 0, 0, 0, KIND_TURN), 0);
    send(beat(0, 0, -546, 0, 0, 0, KIND_TURN), 0);
    send(beat(0, 0, 545, 0, 0, 0, KIND_TURN), 0);
    send(beat(0, 0, -32768, 0, 0, 0, KIND_TURN), 0);
    send(beat(0, 0, 3, 0, 0, 0, KIND_TURN), 0);
    random_run(140);
    drain();

    write_all(15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
    random_run(130);
    drain();

    write_all(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0);
    write_reg(REG_SPARE, 15'd1234);
    random_run(130);
    drain();

    write_all(15'd2000, 15'd30000, 15'd300, 15'd5000, 15'd600, 15'd200);
    random_run(130);
    drain();

    write_all(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 12000)),
              15'($urandom_range(0, 3000)), 15'($urandom_range(0, 32767)),
              15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)));
    random_run(150);
    drain();

    write_all(15'd9830, 15'd1, 15'd100, 15'd1000, 15'd31, 15'd15646);
    random_run(150);
    drain();

    if (board.errors == 0) begin
      $display("waypoint_step_tracker: match");
    end else begin
      $display("waypoint_step_tracker: mismatch");
    end
    $finish;
  end

endmodule
